// ===== rtl/core/lcr_pkg.sv =====
`default_nettype none

package lcr_pkg;

   localparam int STEPS_W   = 16;                 // width of the steps field
   localparam int VALUE_W   = 32;                 // Q16.16 value width
   localparam int EXT_W     = 16;                 // extra fraction bits kept internally
   localparam int LEVEL_W   = VALUE_W + EXT_W;    // Q16.32 level
   localparam int STEP_W    = LEVEL_W + 1;        // Q17.32 increment
   localparam int BIT_CNT_W = $clog2(STEP_W);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_RESET = 2'd2
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/core/linear_control_ramp_core.sv =====
`default_nettype none

// channel   dir  ports                                        accepted when
// req       in   req_operation, req_value, req_steps          req_valid & !req_stall
// rsp       out  rsp_current_value, rsp_active                rsp_valid & !rsp_stall
//
// Tick, reset and set with zero steps are answered from idle, registered in the cycle after acceptance.
// Set with nonzero steps runs a restoring divider one quotient bit per cycle:
// accept, magnitude, a divide step per quotient bit, sign fixup; req stalls meanwhile.
// Synchronous active-high reset clears the ramp to zero and idles.
// A waiting output word stalls req only while rsp_stall holds it.

module linear_control_ramp_core
   import lcr_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [STEPS_W-1:0]   req_steps,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_current_value,
   output logic                      rsp_active
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ABS,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [LEVEL_W-1:0]          level_ff, level_in;
   logic [VALUE_W-1:0]          goal_ff, goal_in;
   logic [STEP_W-1:0]           step_size_ff, step_size_in;
   logic [COUNT_WIDTH-1:0]      steps_left_ff, steps_left_in;
   logic [STEP_W-1:0]           num_ff, num_in;
   logic [COUNT_WIDTH-1:0]      rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]      div_ff, div_in;
   logic                        neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]          rsp_value_ff, rsp_value_in;
   logic                        rsp_active_ff, rsp_active_in;

   logic                        out_free;
   logic                        req_take;
   logic [COUNT_WIDTH-1:0]      cnt_sat;
   logic [COUNT_WIDTH-1:0]      steps_dec;
   logic [STEP_W-1:0]           diff;
   logic [COUNT_WIDTH:0]        trial;
   logic [COUNT_WIDTH:0]        trial_sub;
   logic [LEVEL_W-1:0]          goal_level;

   if (COUNT_WIDTH >= STEPS_W) begin : g_cnt_wide
      assign cnt_sat = COUNT_WIDTH'(req_steps);
   end else begin : g_cnt_narrow
      // saturate counts that do not fit the counter
      assign cnt_sat = (|req_steps[STEPS_W-1:COUNT_WIDTH]) ? '1
                                                           : req_steps[COUNT_WIDTH-1:0];
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   assign goal_level = {req_value, {EXT_W{1'b0}}};
   assign diff       = {goal_level[LEVEL_W-1], goal_level} - {level_ff[LEVEL_W-1], level_ff};
   assign steps_dec  = steps_left_ff - COUNT_WIDTH'(1);
   assign trial      = {rem_ff, num_ff[STEP_W-1]};
   assign trial_sub  = trial - {1'b0, div_ff};

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      goal_in       = goal_ff;
      step_size_in  = step_size_ff;
      steps_left_in = steps_left_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      neg_in        = neg_ff;
      bit_cnt_in    = bit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_active_in = rsp_active_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // default result: state after the word
               rsp_valid_in  = 1'b1;
               rsp_value_in  = level_ff[LEVEL_W-1:EXT_W];
               rsp_active_in = steps_left_ff != '0;
               unique case (op_type'(req_operation))
                  OP_RESET: begin
                     level_in      = goal_level;
                     goal_in       = req_value;
                     step_size_in  = '0;
                     steps_left_in = '0;
                     rsp_value_in  = req_value;
                     rsp_active_in = 1'b0;
                  end
                  OP_SET: begin
                     goal_in       = req_value;
                     steps_left_in = cnt_sat;
                     if (cnt_sat == '0) begin
                        level_in      = goal_level;
                        step_size_in  = '0;
                        rsp_value_in  = req_value;
                        rsp_active_in = 1'b0;
                     end else begin
                        // hold the result until the increment is known
                        rsp_valid_in = 1'b0;
                        num_in       = diff;
                        neg_in       = diff[STEP_W-1];
                        div_in       = cnt_sat;
                        state_in     = ST_ABS;
                     end
                  end
                  OP_TICK: begin
                     if (steps_left_ff != '0) begin
                        steps_left_in = steps_dec;
                        rsp_active_in = steps_dec != '0;
                        if (steps_dec == '0) begin
                           level_in     = {goal_ff, {EXT_W{1'b0}}};
                           step_size_in = '0;
                           rsp_value_in = goal_ff;
                        end else begin
                           level_in     = level_ff + step_size_ff[LEVEL_W-1:0];
                           rsp_value_in = level_in[LEVEL_W-1:EXT_W];
                        end
                     end
                  end
                  default: begin
                     // unused code: report state, change nothing
                  end
               endcase
            end
         end
         ST_ABS: begin
            if (neg_ff) begin
               num_in = -num_ff;
            end
            rem_in     = '0;
            bit_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step: shift in a dividend bit, shift the quotient bit into num
            if (!trial_sub[COUNT_WIDTH]) begin
               rem_in = trial_sub[COUNT_WIDTH-1:0];
               num_in = {num_ff[STEP_W-2:0], 1'b1};
            end else begin
               rem_in = trial[COUNT_WIDTH-1:0];
               num_in = {num_ff[STEP_W-2:0], 1'b0};
            end
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(STEP_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               step_size_in  = neg_ff ? -num_ff : num_ff;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = level_ff[LEVEL_W-1:EXT_W];
               rsp_active_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         level_ff      <= '0;
         goal_ff       <= '0;
         step_size_ff  <= '0;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         goal_ff       <= goal_in;
         step_size_ff  <= step_size_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      neg_ff        <= neg_in;
      bit_cnt_ff    <= bit_cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_value = rsp_value_ff;
   assign rsp_active        = rsp_active_ff;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
   import lcr_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;   // unused operation code
   localparam int WORD_TARGET = 1500;

   typedef struct packed {
      logic signed [VALUE_W-1:0] current_value;
      logic                      active;
   } ramp_out_type;

   class ramp_scoreboard;
      longint       ramp_level;   // Q16.32
      longint       ramp_goal;    // Q16.16
      longint       ramp_inc;     // Q17.32
      int unsigned  ticks_left;
      ramp_out_type expected_words[$];
      int           errors;

      function new();
         ramp_level = 0;
         ramp_goal  = 0;
         ramp_inc   = 0;
         ticks_left = 0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // Advance the ramp by one accepted word and queue the word it returns.
      function void note_word(logic [1:0] op, logic signed [VALUE_W-1:0] value,
                              logic [STEPS_W-1:0] steps);
         ramp_out_type exp_word;
         case (op)
            OP_RESET: begin
               ramp_goal  = longint'(value);
               ramp_level = ramp_goal * 65536;
               ramp_inc   = 0;
               ticks_left = 0;
            end
            OP_SET: begin
               ramp_goal  = longint'(value);
               ticks_left = steps;
               if (steps == 0) begin
                  ramp_level = ramp_goal * 65536;
                  ramp_inc   = 0;
               end else begin
                  ramp_inc = (ramp_goal * 65536 - ramp_level) / longint'(steps);
               end
            end
            OP_TICK: begin
               if (ticks_left != 0) begin
                  ticks_left--;
                  if (ticks_left == 0) begin
                     ramp_level = ramp_goal * 65536;
                     ramp_inc   = 0;
                  end else begin
                     ramp_level += ramp_inc;
                  end
               end
            end
            default: ;
         endcase
         exp_word.current_value = VALUE_W'(ramp_level >>> 16);
         exp_word.active        = (ticks_left != 0);
         expected_words = {expected_words, exp_word};
      endfunction

      function void check_word(logic signed [VALUE_W-1:0] current_value, logic active);
         ramp_out_type exp_word;
         if (expected_words.size() == 0) begin
            $error("rsp word with nothing expected: current_value %h active %b",
                   current_value, active);
            errors++;
            return;
         end
         exp_word = expected_words.pop_front();
         if (current_value !== exp_word.current_value) begin
            $error("current_value: expected %h, got %h", exp_word.current_value,
                   current_value);
            errors++;
         end
         if (active !== exp_word.active) begin
            $error("active: expected %b, got %b", exp_word.active, active);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_operation = OP_TICK;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [STEPS_W-1:0]        req_steps = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_current_value;
   logic                      rsp_active;

   ramp_scoreboard sb = new();
   int req_gap_max = 14;
   int rsp_hold_max = 14;
   int words_sent = 0;

   linear_control_ramp_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .req_steps         (req_steps),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_value (rsp_current_value),
      .rsp_active        (rsp_active)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #24000000;
      $display("simulation failed");
      $finish;
   end

   // Call at a rising edge; returns at the edge where the word was taken.
   task automatic send_word(logic [1:0] op, logic signed [VALUE_W-1:0] value,
                            logic [STEPS_W-1:0] steps);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      req_steps     <= steps;
      do @(posedge clock); while (req_stall);
      sb.note_word(op, value, steps);
      if (op != OP_SPARE) words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic take_results();
      int hold;
      forever begin
         hold = $urandom_range(0, rsp_hold_max);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_word(rsp_current_value, rsp_active);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [STEPS_W-1:0] pick_steps();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return STEPS_W'($urandom_range(13, 65535));
         2:       return '1;
         default: return STEPS_W'($urandom_range(1, 12));
      endcase
   endfunction

   initial begin
      logic [STEPS_W-1:0] n;
      int ticks;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         take_results();
      join_none

      // directed: extremes, every operation, idle tick, spare code, cut-short ramps
      send_word(OP_RESET, 32'h7FFF_FFFF, 16'h0000);
      send_word(OP_SET, 32'h8000_0000, 16'hFFFF);
      repeat (3) send_word(OP_TICK, 32'h7FFF_FFFF, 16'hFFFF);
      send_word(OP_SET, 32'h7FFF_FFFF, 16'd1);
      send_word(OP_TICK, 32'h0000_0000, 16'h0000);
      send_word(OP_TICK, 32'h8000_0000, 16'h1234);
      send_word(OP_SET, 32'h1234_5678, 16'd0);
      send_word(OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(OP_SET, 32'hFFFA_8000, 16'd3);
      repeat (4) send_word(OP_TICK, $urandom(), 16'($urandom()));
      send_word(OP_RESET, 32'h8000_0000, 16'hFFFF);
      send_word(OP_SET, 32'h0000_0000, 16'd2);
      send_word(OP_SPARE, 32'h5555_5555, 16'hAAAA);
      send_word(OP_TICK, 32'hAAAA_AAAA, 16'h5555);
      send_word(OP_SET, 32'h0000_0001, 16'd7);
      send_word(OP_TICK, 32'h0000_0000, 16'h0000);
      send_word(OP_RESET, 32'h0001_0000, 16'd9);
      send_word(OP_TICK, 32'h0000_0000, 16'h0000);
      wait_drained();

      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 15) == 0) begin
            req_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 14;
            rsp_hold_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
         end
         if ($urandom_range(0, 24) == 0) wait_drained();
         case ($urandom_range(0, 9))
            0: send_word(OP_RESET, pick_value(), 16'($urandom()));
            1: send_word(2'($urandom()), $urandom(), 16'($urandom()));
            default: begin
               n = pick_steps();
               send_word(OP_SET, pick_value(), n);
               // long ramps get interrupted by the next command
               if (n > 20) ticks = $urandom_range(0, 20);
               else if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, n);
               else ticks = n + $urandom_range(0, 2);
               repeat (ticks) send_word(OP_TICK, $urandom(), 16'($urandom()));
            end
         endcase
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lcr_pkg.sv
rtl/core/linear_control_ramp_core.sv
bench/tb.sv
